@@ design/ctf_pkg.sv @@
// Package for the color transfer function table: types, constants, helpers.
`timescale 1ns / 1ps
package ctf_pkg;
  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int PW = 17;
  localparam int CW = 18;
  localparam int IW = 6;
  localparam int NW = 7;

  typedef enum logic [2:0] {
    K_LOOKUP  = 3'd0,
    K_INS_COL = 3'd1,
    K_INS_INT = 3'd2,
    K_DELETE  = 3'd3,
    K_MOVE    = 3'd4,
    K_SET_COL = 3'd5,
    K_READ    = 3'd6,
    K_COMPACT = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DIV, S_SHIFT, S_COMPACT, S_OUT
  } state_t;

  typedef struct packed {
    logic [PW-1:0] pos;
    logic [PW-1:0] r;
    logic [PW-1:0] g;
    logic [PW-1:0] b;
  } point_t;

  // Shift commands broadcast to every cell.
  typedef enum logic [1:0] {
    SH_NONE, SH_INSERT, SH_REMOVE
  } shift_t;

  typedef struct packed {
    shift_t       op;
    logic [IW+4:0] at;
    point_t       pt;
    logic         wr;
    logic [IW+4:0] wr_idx;
    logic         wr_pos_only;
  } cell_cmd_t;

  function automatic logic [PW-1:0] sat_color(input logic [CW-1:0] v, input int one);
    if (v[CW-1]) return '0;
    if ({1'b0, v} > CW'(one)) return PW'(one);
    return v[PW-1:0];
  endfunction
endpackage

@@ design/ctf_cell.sv @@
// One table cell: holds a control point and shifts with its neighbors.
`timescale 1ns / 1ps
module ctf_cell #(
  parameter int AW = 11,
  parameter int MY_IDX = 0,
  parameter ctf_pkg::point_t RST_PT = '0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctf_pkg::cell_cmd_t   cmd,
  input  ctf_pkg::point_t      left_pt,
  input  ctf_pkg::point_t      right_pt,
  output ctf_pkg::point_t      pt
);
  import ctf_pkg::*;
  point_t pt_r, pt_nxt;
  logic [AW-1:0] me;
  assign me = AW'(MY_IDX);
  always_comb begin
    pt_nxt = pt_r;
    case (cmd.op)
      SH_INSERT: begin
        if (me == cmd.at[AW-1:0]) pt_nxt = cmd.pt;
        else if (me > cmd.at[AW-1:0]) pt_nxt = left_pt;
      end
      SH_REMOVE: if (me >= cmd.at[AW-1:0]) pt_nxt = right_pt;
      default: ;
    endcase
    if (cmd.wr && me == cmd.wr_idx[AW-1:0]) begin
      pt_nxt.pos = cmd.pt.pos;
      if (!cmd.wr_pos_only) begin
        pt_nxt.r = cmd.pt.r; pt_nxt.g = cmd.pt.g; pt_nxt.b = cmd.pt.b;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) pt_r <= RST_PT;
    else pt_r <= pt_nxt;
  end
  assign pt = pt_r;
endmodule

@@ design/ctf_div.sv @@
// Serial restoring divider for the interpolation quotient.
`timescale 1ns / 1ps
module ctf_div #(
  parameter int NB = 35,
  parameter int DB = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NB-1:0] num,
  input  logic [DB-1:0] den,
  output logic          done,
  output logic [NB-1:0] quo
);
  logic [NB-1:0] q_r;
  logic [DB:0]   rem_r;
  logic [DB-1:0] d_r;
  logic [$clog2(NB+1)-1:0] cnt_r;
  logic busy_r;
  logic [DB+1:0] trial;
  assign trial = {rem_r, q_r[NB-1]} - {2'b0, d_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done <= 1'b0;
    end else begin
      done <= !start && busy_r && (cnt_r == 1);
      if (start) begin
        busy_r <= 1'b1; q_r <= num; d_r <= den; rem_r <= '0;
        cnt_r <= ($clog2(NB+1))'(NB);
      end else if (busy_r) begin
        if (!trial[DB+1]) begin
          rem_r <= trial[DB:0]; q_r <= {q_r[NB-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[DB-1:0], q_r[NB-1]}; q_r <= {q_r[NB-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 1) busy_r <= 1'b0;
      end
    end
  end
  assign quo = q_r;
endmodule

@@ design/color_transfer_function_table.sv @@
// Top level of the color transfer function table.
// Channel | dir | fields
// in_     | in  | tdata: position, entry_index, red_in, green_in, blue_in; tuser: kind
// out_    | out | tdata: red_out, green_out, blue_out, position_out, count_out, status
// A lookup or interpolated insert scans the cell row one entry per cycle, then
// runs three serial divisions, one per color channel.
// Inserts, deletes and compaction shift the cells of the row to open or close a slot.
// Reset (synchronous, active low) restores the four default points.
// A result waits in the output register until taken; stalls hold all state.
`timescale 1ns / 1ps
module color_transfer_function_table #(
  parameter int MAX_POINTS = ctf_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = ctf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // position, entry_index, red_in, green_in, blue_in
  input  logic [2:0]  in_tuser,  // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata  // red, green, blue, position, count, status
);
  import ctf_pkg::*;
  localparam int ONE = 1 << FRAC_BITS;
  localparam int AW  = $clog2(MAX_POINTS + 1);
  localparam int NB  = 2 * PW + 1;

  cell_cmd_t cmd;
  point_t    cells [MAX_POINTS];
  point_t    zp;
  assign zp = '0;

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    localparam point_t RP =
      (k == 1) ? point_t'{pos: PW'(ONE >> 1), r: PW'(ONE), g: '0, b: '0} :
      (k == 2) ? point_t'{pos: PW'((ONE >> 1) + (ONE >> 2)), r: PW'(ONE), g: PW'(ONE),
                          b: '0} :
      (k == 3) ? point_t'{pos: PW'(ONE), r: '0, g: PW'(ONE), b: '0} : point_t'('0);
    ctf_cell #(.AW(IW+5), .MY_IDX(k), .RST_PT(RP)) u_cell (
      .clk, .rst_n, .cmd,
      .left_pt (k == 0 ? zp : cells[(k == 0) ? 0 : k-1]),
      .right_pt(k == MAX_POINTS-1 ? zp : cells[(k == MAX_POINTS-1) ? k : k+1]),
      .pt(cells[k]));
  end

  state_t state_r, state_nxt;
  kind_t  kind_r;
  logic [PW-1:0] p_r;
  logic [IW-1:0] idx_r;
  logic [PW-1:0] rs_r, gs_r, bs_r;
  logic [AW-1:0] cnt_r, i_r;
  logic [1:0]    ch_r;
  point_t lo_r, hi_r;
  logic [PW-1:0] res_r [3];
  logic [79:0]   out_r;
  logic          ov_r;

  // divider
  logic          dstart;
  logic [NB-1:0] dnum, dquo;
  logic [PW-1:0] dden;
  logic          ddone;
  ctf_div #(.NB(NB), .DB(PW)) u_div (
    .clk, .rst_n, .start(dstart), .num(dnum), .den(dden), .done(ddone), .quo(dquo));

  logic [NB-1:0] prod_r;
  logic          pvalid_r;

  assign dden = hi_r.pos - lo_r.pos;
  assign dnum = prod_r;

  point_t cur, nx, pv;
  assign cur = cells[i_r[AW-1:0] < AW'(MAX_POINTS) ? i_r[$clog2(MAX_POINTS)-1:0] : '0];
  assign nx  = cells[(i_r + 1'b1) < AW'(MAX_POINTS) ?
                     $clog2(MAX_POINTS)'(i_r + 1'b1) : '0];
  assign pv  = cells[(i_r != 0) ? $clog2(MAX_POINTS)'(i_r - 1'b1) : '0];

  logic p_ok, interior, valid_idx, full;
  assign p_ok      = p_r <= PW'(ONE);
  assign interior  = idx_r >= 1 && (AW'(idx_r) + 1'b1) < cnt_r;
  assign valid_idx = AW'(idx_r) < cnt_r;
  assign full      = cnt_r >= AW'(MAX_POINTS);

  logic fin, fstat;
  logic [PW-1:0] fr, fg, fb, fpos;
  logic [AW-1:0] cnt_nxt, i_nxt;
  logic [1:0]    ch_nxt;
  point_t lo_nxt, hi_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    fin = 1'b0; fstat = 1'b0; fr = '0; fg = '0; fb = '0; fpos = '0;
    cnt_nxt = cnt_r; i_nxt = i_r; ch_nxt = ch_r; lo_nxt = lo_r; hi_nxt = hi_r;
    dstart = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_tvalid) begin
        state_nxt = S_SCAN; i_nxt = '0;
      end
      S_SCAN: begin
        unique case (kind_r)
          K_LOOKUP, K_INS_COL, K_INS_INT: begin
            if (!p_ok || ((kind_r != K_LOOKUP) && full)) begin
              fin = 1'b1; fstat = 1'b1;
            end else if (p_r == '0 && kind_r == K_LOOKUP) begin
              fin = 1'b1; fr = cells[0].r; fg = cells[0].g; fb = cells[0].b;
            end else if (p_r == '0 && kind_r == K_INS_INT) begin
              cmd.op = SH_INSERT; cmd.at = (IW+5)'(1); cmd.pt = cells[0]; cmd.pt.pos = '0;
              cnt_nxt = cnt_r + 1'b1; fin = 1'b1;
            end else if (i_r < cnt_r && p_r > cur.pos) begin
              i_nxt = i_r + 1'b1;
            end else if (kind_r == K_INS_COL) begin
              if ((i_r == 0 ? AW'(1) : i_r) >= cnt_r) begin fin = 1'b1; fstat = 1'b1; end
              else begin
                cmd.op = SH_INSERT; cmd.at = (IW+5)'(i_r == 0 ? AW'(1) : i_r);
                cmd.pt = '{pos: p_r, r: rs_r, g: gs_r, b: bs_r};
                cnt_nxt = cnt_r + 1'b1; fin = 1'b1;
              end
            end else if (i_r == 0 || i_r >= cnt_r ||
                         (kind_r == K_INS_INT && p_r >= cur.pos)) begin
              fin = 1'b1; fstat = 1'b1;
            end else begin
              lo_nxt = pv; hi_nxt = cur; ch_nxt = 2'd0; state_nxt = S_DIV;
            end
          end
          K_DELETE: begin
            if (!interior) begin fin = 1'b1; fstat = 1'b1; end
            else begin
              cmd.op = SH_REMOVE; cmd.at = (IW+5)'(idx_r);
              cnt_nxt = cnt_r - 1'b1; fin = 1'b1;
            end
          end
          K_MOVE: begin
            if (!interior || !p_ok) begin fin = 1'b1; fstat = 1'b1; end
            else begin
              cmd.wr = 1'b1; cmd.wr_pos_only = 1'b1; cmd.wr_idx = (IW+5)'(idx_r);
              cmd.pt.pos = p_r;
              if (p_r < cells[idx_r - 1'b1].pos) cmd.pt.pos = cells[idx_r - 1'b1].pos;
              if (cmd.pt.pos > cells[idx_r + 1'b1].pos) cmd.pt.pos = cells[idx_r + 1'b1].pos;
              fin = 1'b1;
            end
          end
          K_SET_COL: begin
            if (!valid_idx) begin fin = 1'b1; fstat = 1'b1; end
            else begin
              cmd.wr = 1'b1; cmd.wr_idx = (IW+5)'(idx_r);
              cmd.pt = '{pos: cells[idx_r].pos, r: rs_r, g: gs_r, b: bs_r};
              fin = 1'b1;
            end
          end
          K_READ: begin
            fin = 1'b1;
            if (!valid_idx) fstat = 1'b1;
            else begin
              fr = cells[idx_r].r; fg = cells[idx_r].g; fb = cells[idx_r].b;
              fpos = cells[idx_r].pos;
            end
          end
          default: begin
            i_nxt = AW'(1); state_nxt = S_COMPACT;
          end
        endcase
      end
      S_DIV: begin
        if (pvalid_r) dstart = 1'b1;
        if (ddone) begin
          if (ch_r == 2'd2) state_nxt = S_SHIFT;
          else ch_nxt = ch_r + 1'b1;
        end
      end
      S_SHIFT: begin
        if (kind_r == K_LOOKUP) begin
          fin = 1'b1; fr = res_r[0]; fg = res_r[1]; fb = res_r[2];
        end else begin
          cmd.op = SH_INSERT; cmd.at = (IW+5)'(i_r);
          cmd.pt = '{pos: p_r, r: res_r[0], g: res_r[1], b: res_r[2]};
          cnt_nxt = cnt_r + 1'b1; fin = 1'b1;
        end
      end
      S_COMPACT: begin
        if (i_r + 1'b1 >= cnt_r) fin = 1'b1;
        else if (pv.pos == cur.pos && nx.pos == cur.pos) begin
          cmd.op = SH_REMOVE; cmd.at = (IW+5)'(i_r); cnt_nxt = cnt_r - 1'b1;
        end else i_nxt = i_r + 1'b1;
      end
      S_OUT: if (!ov_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (fin) state_nxt = S_OUT;
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= AW'(4); ov_r <= 1'b0; pvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; i_r <= i_nxt;
      lo_r <= lo_nxt; hi_r <= hi_nxt;
      // product registered before the divider starts
      pvalid_r <= (state_r == S_SCAN && state_nxt == S_DIV) ||
                  (state_r == S_DIV && ddone && ch_r != 2'd2);
      if (state_r == S_DIV && ddone) res_r[ch_r] <= dquo[PW-1:0];
      if (state_r == S_SCAN && state_nxt == S_DIV)
        prod_r <= NB'(pv.r) * NB'(cur.pos - p_r) + NB'(cur.r) * NB'(p_r - pv.pos);
      else if (state_r == S_DIV && ddone && ch_r != 2'd2)
        prod_r <= (ch_r == 2'd0)
          ? NB'(lo_r.g) * NB'(hi_r.pos - p_r) + NB'(hi_r.g) * NB'(p_r - lo_r.pos)
          : NB'(lo_r.b) * NB'(hi_r.pos - p_r) + NB'(hi_r.b) * NB'(p_r - lo_r.pos);
      ch_r <= ch_nxt;
      if (in_tvalid && in_tready) begin
        kind_r <= kind_t'(in_tuser);
        p_r   <= in_tdata[16:0];
        idx_r <= in_tdata[22:17];
        rs_r  <= sat_color(in_tdata[40:23], ONE);
        gs_r  <= sat_color(in_tdata[58:41], ONE);
        bs_r  <= sat_color(in_tdata[76:59], ONE);
      end
      if (fin) begin
        ov_r <= 1'b1;
        out_r <= {4'b0, fstat, NW'(cnt_nxt), fpos, fb, fg, fr};
      end else if (out_tvalid && out_tready) ov_r <= 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;
endmodule
